[sv/page_frame_table_eviction_macros.svh]
// Assertion macros for the page frame table.
`ifndef PAGE_FRAME_TABLE_EVICTION_MACROS_SVH
`define PAGE_FRAME_TABLE_EVICTION_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PFTE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFTE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFTE_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define PFTE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

[sv/pfte_pkg.sv]
// Shared types and codes for the page frame table.
package pfte_pkg;

    // One frame slot as stored in the table memory (63 bits).
    typedef struct packed {
        logic        valid;
        logic [7:0]  owner;
        logic [19:0] page;
        logic        kind;
        logic        acc;
        logic        dirty;
        logic [30:0] stamp;
    } entry_t;

    // Candidate flags reported by the scan unit.
    typedef struct packed {
        logic free_found;
        logic unacc_found;
        logic min_found;
    } cand_flags_t;

    // Request modes
    localparam logic [1:0] MODE_ALLOC      = 2'd0;
    localparam logic [1:0] MODE_FREE_ONE   = 2'd1;
    localparam logic [1:0] MODE_FREE_OWNER = 2'd2;
    localparam logic [1:0] MODE_ACCESS     = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EVICT = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;

    // Writeback target
    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_FILE = 2'd1;
    localparam logic [1:0] WB_SWAP = 2'd2;

    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

endpackage

[sv/page_frame_table_eviction.sv]
// Page frame table with free-slot allocation and NRU/oldest-first eviction.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_valid / s_ready  | mode, owner_id, page_tag, page_kind,
//          |     |                    | frame_index, was_written, access_time, swap_full
//  m_      | out | m_valid / m_ready  | status, granted_frame, writeback,
//          |     |                    | victim_owner, victim_page
//
// Sequence: allocate and free-owner each make one full pass over the table memory
//   through its single read port; an allocate that evicts then reads the victim
//   slot once more. Free-one clears a single slot; record-access reads the slot and
//   writes it back (no write when the index is past the table end or the slot is not valid).
// Reset: synchronous, active low. After reset a clearing pass writes every slot
//   to zero, with s_ready low.
// Stalls: one request is in work at a time. A finished result sits in the output
//   register; the next request is taken while it waits, and its own result
//   holds in the sequencer until the output register frees up.

`include "page_frame_table_eviction_macros.svh"

module page_frame_table_eviction #(
    parameter int FRAMES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_owner_id,
    input  logic [19:0] s_page_tag,
    input  logic        s_page_kind,
    input  logic [5:0]  s_frame_index,
    input  logic        s_was_written,
    input  logic [30:0] s_access_time,
    input  logic        s_swap_full,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_granted_frame,
    output logic [1:0]  m_writeback,
    output logic [7:0]  m_victim_owner,
    output logic [19:0] m_victim_page
);
    import pfte_pkg::*;

    localparam int         SW       = $clog2(FRAMES);
    localparam logic [SW:0] FRAMES_C = (SW+1)'(FRAMES);

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_FREE   = 4'd2;
    localparam logic [3:0] S_ACC_RD = 4'd3;
    localparam logic [3:0] S_ACC_WR = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_PICK   = 4'd6;
    localparam logic [3:0] S_VDEC   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [3:0]    state_reg, state_next;
    logic [SW:0]   cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic          m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    logic [SW-1:0] pend_slot_reg, pend_slot_next;
    logic [SW-1:0] victim_reg, victim_next;
    logic [1:0]    req_mode_reg, req_mode_next;
    logic [7:0]    req_owner_reg, req_owner_next;
    logic [19:0]   req_page_reg, req_page_next;
    logic          req_kind_reg, req_kind_next;
    logic [5:0]    req_idx_reg, req_idx_next;
    logic          req_wr_reg, req_wr_next;
    logic [30:0]   req_time_reg, req_time_next;
    logic          req_sfull_reg, req_sfull_next;

    logic [1:0]    res_status_reg, res_status_next;
    logic [5:0]    res_granted_reg, res_granted_next;
    logic [1:0]    res_wb_reg, res_wb_next;
    logic [7:0]    res_owner_reg, res_owner_next;
    logic [19:0]   res_page_reg, res_page_next;

    logic [1:0]    m_status_reg, m_status_next;
    logic [5:0]    m_granted_reg, m_granted_next;
    logic [1:0]    m_wb_reg, m_wb_next;
    logic [7:0]    m_owner_reg, m_owner_next;
    logic [19:0]   m_page_reg, m_page_next;

    // ------------------------------------------------------------------
    // Frame table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    entry_t        mem_reg [FRAMES];
    entry_t        rd_data_reg;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    entry_t        wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    // ------------------------------------------------------------------
    // Scan unit
    // ------------------------------------------------------------------
    logic          cand_start;
    logic          cand_load;
    cand_flags_t   cand_flags;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] unacc_slot;
    logic [SW-1:0] min_slot;

    pfte_cand #(
        .SW (SW)
    ) u_cand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cand_start),
        .load       (cand_load),
        .slot       (pend_slot_reg),
        .entry      (rd_data_reg),
        .flags      (cand_flags),
        .free_slot  (free_slot),
        .unacc_slot (unacc_slot),
        .min_slot   (min_slot)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // slot number to the 6-bit granted_frame field (low bits, zero-extended)
    function automatic logic [5:0] low6(input logic [SW-1:0] s);
        logic [SW+5:0] x;
        x = {6'b0, s};
        return x[5:0];
    endfunction

    logic [SW+5:0] idx_ext;
    logic [SW-1:0] idx_addr;
    logic          idx_ok;
    logic [SW-1:0] victim_sel;
    entry_t        fill_entry;

    assign idx_ext  = {{SW{1'b0}}, req_idx_reg};
    assign idx_addr = idx_ext[SW-1:0];
    assign idx_ok   = (32'(req_idx_reg) < 32'(FRAMES));

    // First not-accessed slot, else strictly oldest, else slot 0 (table is full).
    assign victim_sel = cand_flags.unacc_found ? unacc_slot :
                        cand_flags.min_found   ? min_slot   : '0;

    always_comb begin
        fill_entry       = '0;
        fill_entry.valid = 1'b1;
        fill_entry.owner = req_owner_reg;
        fill_entry.page  = req_page_reg;
        fill_entry.kind  = req_kind_reg;
        fill_entry.stamp = req_time_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        pend_slot_next   = pend_slot_reg;
        victim_next      = victim_reg;
        req_mode_next    = req_mode_reg;
        req_owner_next   = req_owner_reg;
        req_page_next    = req_page_reg;
        req_kind_next    = req_kind_reg;
        req_idx_next     = req_idx_reg;
        req_wr_next      = req_wr_reg;
        req_time_next    = req_time_reg;
        req_sfull_next   = req_sfull_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_wb_next      = res_wb_reg;
        res_owner_next   = res_owner_reg;
        res_page_next    = res_page_reg;
        m_status_next    = m_status_reg;
        m_granted_next   = m_granted_reg;
        m_wb_next        = m_wb_reg;
        m_owner_next     = m_owner_reg;
        m_page_next      = m_page_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_addr          = '0;
        cand_start       = 1'b0;
        cand_load        = 1'b0;
        s_ready          = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[SW-1:0];
                if (cnt_reg == FRAMES_C - 1'b1) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_mode_next    = s_mode;
                    req_owner_next   = s_owner_id;
                    req_page_next    = s_page_tag;
                    req_kind_next    = s_page_kind;
                    req_idx_next     = s_frame_index;
                    req_wr_next      = s_was_written;
                    req_time_next    = s_access_time;
                    req_sfull_next   = s_swap_full;
                    res_status_next  = ST_OK;
                    res_granted_next = '0;
                    res_wb_next      = WB_NONE;
                    res_owner_next   = '0;
                    res_page_next    = '0;
                    case (s_mode)
                        MODE_ALLOC, MODE_FREE_OWNER: begin
                            cnt_next   = '0;
                            cand_start = 1'b1;
                            state_next = S_SCAN;
                        end
                        MODE_FREE_ONE: state_next = S_FREE;
                        MODE_ACCESS:   state_next = S_ACC_RD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end

            S_FREE: begin
                // contents of a free slot are never read back, so write zero
                wr_en      = idx_ok;
                wr_addr    = idx_addr;
                state_next = S_DONE;
            end

            S_ACC_RD: begin
                rd_addr    = idx_addr;
                state_next = idx_ok ? S_ACC_WR : S_DONE;
            end

            S_ACC_WR: begin
                wr_en         = rd_data_reg.valid;
                wr_addr       = idx_addr;
                wr_data       = rd_data_reg;
                wr_data.acc   = 1'b1;
                wr_data.dirty = rd_data_reg.dirty | req_wr_reg;
                wr_data.stamp = req_time_reg;
                state_next    = S_DONE;
            end

            S_SCAN: begin
                // issue one read per cycle; the read data is registered and lands in the next cycle
                if (cnt_reg < FRAMES_C) begin
                    rd_addr        = cnt_reg[SW-1:0];
                    pend_next      = 1'b1;
                    pend_slot_next = cnt_reg[SW-1:0];
                    cnt_next       = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (req_mode_reg == MODE_ALLOC) begin
                        cand_load = 1'b1;
                    end else if (rd_data_reg.valid && (rd_data_reg.owner == req_owner_reg)) begin
                        wr_en   = 1'b1;
                        wr_addr = pend_slot_reg;
                    end
                end
                if ((cnt_reg == FRAMES_C) && !pend_reg) begin
                    state_next = (req_mode_reg == MODE_ALLOC) ? S_PICK : S_DONE;
                end
            end

            S_PICK: begin
                if (cand_flags.free_found) begin
                    wr_en            = 1'b1;
                    wr_addr          = free_slot;
                    wr_data          = fill_entry;
                    res_granted_next = low6(free_slot);
                    state_next       = S_DONE;
                end else begin
                    victim_next = victim_sel;
                    rd_addr     = victim_sel;
                    state_next  = S_VDEC;
                end
            end

            S_VDEC: begin
                if (rd_data_reg.dirty && !rd_data_reg.kind && req_sfull_reg) begin
                    res_status_next = ST_FAIL;
                end else begin
                    wr_en            = 1'b1;
                    wr_addr          = victim_reg;
                    wr_data          = fill_entry;
                    res_status_next  = ST_EVICT;
                    res_granted_next = low6(victim_reg);
                    res_wb_next      = !rd_data_reg.dirty ? WB_NONE :
                                       rd_data_reg.kind   ? WB_FILE : WB_SWAP;
                    res_owner_next   = rd_data_reg.owner;
                    res_page_next    = rd_data_reg.page;
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_granted_next = res_granted_reg;
                    m_wb_next      = res_wb_reg;
                    m_owner_next   = res_owner_reg;
                    m_page_next    = res_page_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_slot_reg   <= pend_slot_next;
        victim_reg      <= victim_next;
        req_mode_reg    <= req_mode_next;
        req_owner_reg   <= req_owner_next;
        req_page_reg    <= req_page_next;
        req_kind_reg    <= req_kind_next;
        req_idx_reg     <= req_idx_next;
        req_wr_reg      <= req_wr_next;
        req_time_reg    <= req_time_next;
        req_sfull_reg   <= req_sfull_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_wb_reg      <= res_wb_next;
        res_owner_reg   <= res_owner_next;
        res_page_reg    <= res_page_next;
        m_status_reg    <= m_status_next;
        m_granted_reg   <= m_granted_next;
        m_wb_reg        <= m_wb_next;
        m_owner_reg     <= m_owner_next;
        m_page_reg      <= m_page_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_frame = m_granted_reg;
    assign m_writeback     = m_wb_reg;
    assign m_victim_owner  = m_owner_reg;
    assign m_victim_page   = m_page_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PFTE_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "overlap")
    `PFTE_ASSERT_NOW(a_clear_blocks, aclk, aresetn, state_reg == S_CLEAR, !s_ready, "ready in clear")
    `PFTE_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= FRAMES_C, "counter past end")
    `PFTE_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_valid), $past(state_reg) == S_DONE, "stray")
    `PFTE_ASSERT_NOW(a_scan_end, aclk, aresetn, state_reg == S_PICK, !pend_reg && cnt_reg == FRAMES_C, "early")

endmodule

[sv/pfte_cand.sv]
// Scan unit: tracks free, not-accessed and oldest candidates over a slot stream.
module pfte_cand #(
    parameter int SW = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  load,
    input  logic [SW-1:0]         slot,
    input  pfte_pkg::entry_t      entry,
    output pfte_pkg::cand_flags_t flags,
    output logic [SW-1:0]         free_slot,
    output logic [SW-1:0]         unacc_slot,
    output logic [SW-1:0]         min_slot
);
    import pfte_pkg::*;

    cand_flags_t   flags_reg, flags_next;
    logic [SW-1:0] free_slot_reg, free_slot_next;
    logic [SW-1:0] unacc_slot_reg, unacc_slot_next;
    logic [SW-1:0] min_slot_reg, min_slot_next;
    logic [30:0]   best_reg, best_next;

    always_comb begin
        flags_next      = flags_reg;
        free_slot_next  = free_slot_reg;
        unacc_slot_next = unacc_slot_reg;
        min_slot_next   = min_slot_reg;
        best_next       = best_reg;
        if (start) begin
            flags_next = '0;
            best_next  = TIME_MAX;
        end else if (load) begin
            if (!entry.valid && !flags_reg.free_found) begin
                flags_next.free_found = 1'b1;
                free_slot_next        = slot;
            end
            if (entry.valid && !entry.acc && !flags_reg.unacc_found) begin
                flags_next.unacc_found = 1'b1;
                unacc_slot_next        = slot;
            end
            // strict compare: earliest slot wins a tie
            if (entry.valid && (entry.stamp < best_reg)) begin
                flags_next.min_found = 1'b1;
                min_slot_next        = slot;
                best_next            = entry.stamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        free_slot_reg  <= free_slot_next;
        unacc_slot_reg <= unacc_slot_next;
        min_slot_reg   <= min_slot_next;
        best_reg       <= best_next;
    end

    assign flags      = flags_reg;
    assign free_slot  = free_slot_reg;
    assign unacc_slot = unacc_slot_reg;
    assign min_slot   = min_slot_reg;

endmodule

[tb/sv/page_frame_table_eviction_tb.sv]
// Self-checking testbench for the page frame table with free-slot allocation and eviction.
`timescale 1ns / 100ps

module page_frame_table_eviction_tb;
    import pfte_pkg::*;

    localparam int FRAMES      = 64;
    localparam int TOTAL_ITEMS = 650;
    localparam logic [30:0] STAMP_TOP = 31'd2147483646;   // largest legal access_time

    // One request as offered on the s_ channel.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  owner;
        logic [19:0] page;
        logic        kind;
        logic [5:0]  slot;
        logic        wr;
        logic [30:0] stamp;
        logic        sfull;
    } req_t;

    // One result as seen on the m_ channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  frame;
        logic [1:0]  wb;
        logic [7:0]  vowner;
        logic [19:0] vpage;
    } grant_t;

    // Shadow copy of the frame table plus the queue of results still owed by the block.
    class frame_table_board;
        entry_t      frames[FRAMES];
        grant_t      grants_due[$];
        int unsigned mismatches;
        int          last_grant;     // slot written by the latest allocate, -1 if it failed
        logic [1:0]  last_status;

        function new();
            foreach (frames[i]) frames[i] = '0;
            mismatches  = 0;
            last_grant  = -1;
            last_status = ST_OK;
        endfunction

        // Random valid slot, -1 if the table is empty.
        function int random_live_slot();
            int base;
            int s;
            base = $urandom_range(FRAMES - 1);
            for (int k = 0; k < FRAMES; k++) begin
                s = (base + k) % FRAMES;
                if (frames[s].valid) return s;
            end
            return -1;
        endfunction

        // Apply one accepted request to the shadow table and queue its result.
        function void note_request(req_t r);
            grant_t      g;
            int          target;
            logic [30:0] oldest;
            g = '0;
            case (r.mode)
                MODE_ALLOC: begin
                    target = -1;
                    for (int s = 0; s < FRAMES; s++)
                        if (target < 0 && !frames[s].valid) target = s;
                    if (target < 0) begin
                        // table full: first unreferenced frame, else strictly oldest stamp
                        for (int s = 0; s < FRAMES; s++)
                            if (target < 0 && frames[s].valid && !frames[s].acc) target = s;
                        if (target < 0) begin
                            oldest = TIME_MAX;
                            for (int s = 0; s < FRAMES; s++)
                                if (frames[s].valid && frames[s].stamp < oldest) begin
                                    oldest = frames[s].stamp;
                                    target = s;
                                end
                        end
                        // no stamp below the maximum: first valid frame
                        if (target < 0)
                            for (int s = 0; s < FRAMES; s++)
                                if (target < 0 && frames[s].valid) target = s;
                        g.status = ST_EVICT;
                        g.frame  = target[5:0];
                        g.vowner = frames[target].owner;
                        g.vpage  = frames[target].page;
                        if (frames[target].dirty) begin
                            if (frames[target].kind) begin
                                g.wb = WB_FILE;
                            end else if (r.sfull) begin
                                // dirty anonymous victim with swap full: nothing changes
                                g        = '0;
                                g.status = ST_FAIL;
                                target   = -1;
                            end else begin
                                g.wb = WB_SWAP;
                            end
                        end
                    end else begin
                        g.status = ST_OK;
                        g.frame  = target[5:0];
                    end
                    if (target >= 0) begin
                        frames[target].valid = 1'b1;
                        frames[target].owner = r.owner;
                        frames[target].page  = r.page;
                        frames[target].kind  = r.kind;
                        frames[target].acc   = 1'b0;
                        frames[target].dirty = 1'b0;
                        frames[target].stamp = r.stamp;
                    end
                    last_grant  = target;
                    last_status = g.status;
                end
                MODE_FREE_ONE: begin
                    frames[r.slot].valid = 1'b0;
                end
                MODE_FREE_OWNER: begin
                    for (int s = 0; s < FRAMES; s++)
                        if (frames[s].valid && frames[s].owner == r.owner)
                            frames[s].valid = 1'b0;
                end
                MODE_ACCESS: begin
                    if (frames[r.slot].valid) begin
                        frames[r.slot].acc = 1'b1;
                        if (r.wr) frames[r.slot].dirty = 1'b1;
                        frames[r.slot].stamp = r.stamp;
                    end
                end
            endcase
            grants_due.push_back(g);
        endfunction

        // Compare one result transfer with the oldest owed result.
        function void check_grant(logic [1:0] status, logic [5:0] frame, logic [1:0] wb,
                                  logic [7:0] vowner, logic [19:0] vpage);
            grant_t want;
            if (grants_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d frame %0d wb %0d owner %0d page %h",
                             status, frame, wb, vowner, vpage);
                return;
            end
            want = grants_due.pop_front();
            if (status !== want.status || frame !== want.frame || wb !== want.wb ||
                vowner !== want.vowner || vpage !== want.vpage) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st %0d fr %0d wb %0d own %0d pg %h / got st %0d fr %0d wb %0d own %0d pg %h",
                             want.status, want.frame, want.wb, want.vowner, want.vpage,
                             status, frame, wb, vowner, vpage);
            end
        endfunction
    endclass

    // DUT inputs start at known values.
    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode        = MODE_ALLOC;
    logic [7:0]  s_owner_id    = '0;
    logic [19:0] s_page_tag    = '0;
    logic        s_page_kind   = 1'b0;
    logic [5:0]  s_frame_index = '0;
    logic        s_was_written = 1'b0;
    logic [30:0] s_access_time = '0;
    logic        s_swap_full   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [5:0]  m_granted_frame;
    logic [1:0]  m_writeback;
    logic [7:0]  m_victim_owner;
    logic [19:0] m_victim_page;

    frame_table_board board;

    int sent          = 0;   // accepted requests
    int send_idle_pct = 9;   // chance that the sender holds s_valid low before an item, drawn anew while it idles
    int recv_idle_pct = 66;  // chance per cycle that m_ready drops
    int results_seen  = 0;
    int hold_left     = 0;   // remaining cycles of the long receiver hold-off
    bit stall_done    = 1'b0;

    page_frame_table_eviction #(
        .FRAMES (FRAMES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_owner_id      (s_owner_id),
        .s_page_tag      (s_page_tag),
        .s_page_kind     (s_page_kind),
        .s_frame_index   (s_frame_index),
        .s_was_written   (s_was_written),
        .s_access_time   (s_access_time),
        .s_swap_full     (s_swap_full),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_frame (m_granted_frame),
        .m_writeback     (m_writeback),
        .m_victim_owner  (m_victim_owner),
        .m_victim_page   (m_victim_page)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop at several times the slowest legal run.
    initial begin
        #1_000_000;
        $display("** page_frame_table_eviction: FAILED **");
        $finish;
    end

    function automatic req_t req(logic [1:0] mode, logic [7:0] owner, logic [19:0] page,
                                 logic kind, logic [5:0] slot, logic wr,
                                 logic [30:0] stamp, logic sfull);
        req_t r;
        r = '{mode, owner, page, kind, slot, wr, stamp, sfull};
        return r;
    endfunction

    // Random content; owners mostly from a small pool so free-owner hits something.
    function automatic req_t random_request(logic [1:0] mode);
        req_t r;
        r.mode  = mode;
        r.owner = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        r.page  = 20'($urandom);
        r.kind  = 1'($urandom_range(1));
        r.slot  = 6'($urandom);
        r.wr    = 1'($urandom_range(1));
        // small stamps now and then, so equal timestamps show up
        r.stamp = ($urandom_range(4) == 0) ? 31'($urandom_range(15))
                                           : 31'($urandom_range(STAMP_TOP));
        r.sfull = 1'($urandom_range(1));
        return r;
    endfunction

    // Offer one request and hold it until the transfer; then record the prediction.
    task automatic send_request(input req_t r);
        // idle profile: sender light / receiver heavy, then swapped, then none
        if (sent < TOTAL_ITEMS / 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 66;
        end else if (sent < 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 9;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= r.mode;
        s_owner_id    <= r.owner;
        s_page_tag    <= r.page;
        s_page_kind   <= r.kind;
        s_frame_index <= r.slot;
        s_was_written <= r.wr;
        s_access_time <= r.stamp;
        s_swap_full   <= r.sfull;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(r);
        sent++;
    endtask

    // Result side: check every transfer, drive m_ready with random gaps and one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                board.check_grant(m_status, m_granted_frame, m_writeback,
                                  m_victim_owner, m_victim_page);
                results_seen <= results_seen + 1;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!stall_done && results_seen >= 80) begin
                // long back-pressure; the sender keeps offering so s_ready must drop
                hold_left  <= 600;
                stall_done <= 1'b1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        req_t r;
        int   pick;
        int   live;
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored requests on empty slots, field extremes, every mode,
        // lowest free slot reuse, free-owner with and without matches.
        send_request(req(MODE_FREE_ONE,   8'd0,   20'h0,     1'b0, 6'd0,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_ACCESS,     8'd0,   20'h0,     1'b0, 6'd63, 1'b1, STAMP_TOP, 1'b1));
        send_request(req(MODE_ALLOC,      8'd255, 20'hFFFFF, 1'b1, 6'd63, 1'b1, STAMP_TOP, 1'b1));
        send_request(req(MODE_ALLOC,      8'd0,   20'h0,     1'b0, 6'd0,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_ALLOC,      8'd7,   20'h12345, 1'b0, 6'd0,  1'b0, 31'd100, 1'b1));
        send_request(req(MODE_ACCESS,     8'd0,   20'h0,     1'b0, 6'd0,  1'b1, 31'd5, 1'b0));
        send_request(req(MODE_ACCESS,     8'd0,   20'h0,     1'b0, 6'd1,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_FREE_ONE,   8'd0,   20'h0,     1'b0, 6'd1,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_ALLOC,      8'd3,   20'hABCDE, 1'b1, 6'd0,  1'b0, 31'd9, 1'b0));
        send_request(req(MODE_FREE_OWNER, 8'd9,   20'h0,     1'b0, 6'd0,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_FREE_OWNER, 8'd255, 20'h0,     1'b0, 6'd0,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_FREE_OWNER, 8'd0,   20'h0,     1'b0, 6'd0,  1'b0, 31'd0, 1'b0));
        send_request(req(MODE_ACCESS,     8'd0,   20'h0,     1'b0, 6'd2,  1'b1, STAMP_TOP, 1'b0));
        send_request(req(MODE_FREE_ONE,   8'd0,   20'h0,     1'b0, 6'd63, 1'b0, 31'd0, 1'b0));

        // Random part: mostly well-formed episodes, some noise.
        while (sent < TOTAL_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // fill the table, reference every frame, then allocate: oldest-first path,
                // dirty victims, swap-full failures; re-touch most new frames so they stay there
                do begin
                    send_request(random_request(MODE_ALLOC));
                end while (board.last_status == ST_OK);
                for (int k = 0; k < FRAMES; k++) begin
                    r      = random_request(MODE_ACCESS);
                    r.slot = k[5:0];
                    send_request(r);
                end
                repeat ($urandom_range(3, 8)) begin
                    send_request(random_request(MODE_ALLOC));
                    if (board.last_grant >= 0 && $urandom_range(3) != 0) begin
                        r      = random_request(MODE_ACCESS);
                        r.slot = board.last_grant[5:0];
                        send_request(r);
                    end
                end
            end else if (pick < 42) begin
                repeat ($urandom_range(1, 10)) send_request(random_request(MODE_ALLOC));
            end else if (pick < 66) begin
                repeat ($urandom_range(1, 12)) begin
                    r    = random_request(MODE_ACCESS);
                    live = board.random_live_slot();
                    if (live >= 0) r.slot = live[5:0];
                    send_request(r);
                end
            end else if (pick < 82) begin
                r    = random_request(MODE_FREE_ONE);
                live = board.random_live_slot();
                if (live >= 0 && $urandom_range(4) != 0) r.slot = live[5:0];
                send_request(r);
            end else if (pick < 88) begin
                r    = random_request(MODE_FREE_OWNER);
                live = board.random_live_slot();
                if (live >= 0 && $urandom_range(3) != 0) r.owner = board.frames[live].owner;
                send_request(r);
            end else begin
                // noise: any mode, any field value
                r       = random_request(2'($urandom));
                r.owner = 8'($urandom);
                send_request(r);
            end
        end
        s_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (board.grants_due.size() != 0) @(posedge aclk);
        repeat (FRAMES + 40) @(posedge aclk);

        if (board.mismatches == 0 && board.grants_due.size() == 0)
            $display("** page_frame_table_eviction: PASSED **");
        else
            $display("** page_frame_table_eviction: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/pfte_pkg.sv
sv/pfte_cand.sv
sv/page_frame_table_eviction.sv
tb/sv/page_frame_table_eviction_tb.sv
